/* sv/tbmq_pkg.sv */
// Shared types and constants for the tiered batch match queue.
// No dependencies; imported by tbmq_ram users and the top level.
package tbmq_pkg;

    localparam int TIER_DEPTH = 16;
    localparam int MAX_SEATS  = 4;
    localparam int NUM_TIERS  = 4;
    localparam int TIER_W     = 2;
    localparam int IDX_W      = $clog2(TIER_DEPTH);
    localparam int CNT_W      = $clog2(TIER_DEPTH + 1);
    localparam int TOT_W      = CNT_W + TIER_W;
    localparam int ADDR_W     = TIER_W + IDX_W;
    localparam int SEAT_W     = 3;

    localparam logic [31:0] LIMIT_ONE_RST   = 32'd100;
    localparam logic [31:0] LIMIT_TWO_RST   = 32'd300;
    localparam logic [31:0] LIMIT_THREE_RST = 32'd500;
    localparam logic [SEAT_W-1:0] SEATS_RST = 3'd2;
    localparam logic [SEAT_W-1:0] SEATS_MIN = 3'd2;

    typedef enum logic [2:0] {
        MODE_JOIN  = 3'd0,
        MODE_LEAVE = 3'd1,
        MODE_POS   = 3'd2,
        MODE_BUILD = 3'd3,
        MODE_STATS = 3'd4,
        MODE_CLEAR = 3'd5
    } mode_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_ALREADY   = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_FULL      = 3'd3,
        ST_NO_MATCH  = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        CFG_TIER_ONE   = 2'd0,
        CFG_TIER_TWO   = 2'd1,
        CFG_TIER_THREE = 2'd2
    } cfg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_POP_RD,
        S_POP_EMIT,
        S_EMIT,
        S_STATS
    } state_t;

    typedef struct packed {
        logic [30:0]        id;
        logic [15:0]        handle;
        logic signed [31:0] score;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic [6:0]         total_count;
        logic [4:0]         tier_count;
        logic [4:0]         position;
        logic [30:0]        room_id;
        logic signed [31:0] score;
        logic [15:0]        handle;
        logic [30:0]        player_id;
        logic [1:0]         tier;
    } result_t;

endpackage

/* sv/tbmq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Read data holds while no read is issued. No dependencies.
module tbmq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* sv/tiered_batch_match_queue.sv */
// Top level of the tiered batch match queue: control sequencer, counters,
// configuration registers and output register. Uses tbmq_pkg and tbmq_ram.
//
// Usage:
//   s_ channel carries one request: s_tuser = mode; s_tdata holds player_id,
//   handle, score, seat_request, room_id. The m_ channel returns results:
//   m_tuser = status, m_tlast marks the final result of a request, m_tdata
//   holds the remaining result fields. cfg_ writes the three score limits
//   (index 0..2); cfg_ready is always high, other indexes are dropped.
//   All entries of the four tiers live in one RAM (tier, slot addressed).
//   Flow from acceptance to the result (output register free); a search
//   compares the entries one by one and steps on tier by tier:
//     join/position: the search, then the result;
//     leave: as position on a hit, then the entries behind the removed one shift;
//     build match: per seat a front pop and a shift of the rest; no ready
//     tier: one result. clear: one result. stats: 1 result a cycle over 4
//     unless stalled. Cost is set by the single RAM read port. A new request is
//   taken once the sequencer is back in idle, even with a result still held.
//   Reset (aresetn low, synchronous) empties all tiers, sets every seat
//   count to two and the limits to 100/300/500; no RAM clearing is needed.
//   A stalled receiver freezes the sequencer at its next result.
module tiered_batch_match_queue
    import tbmq_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [30:0] player_id, [46:31] handle, [78:47] score, [81:79] seat_request,
    // [112:82] room_id, [119:113] zero
    input  logic [119:0] s_tdata,
    // [2:0] mode
    input  logic [2:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [1:0] tier, [32:2] out_player_id, [48:33] out_handle, [80:49] out_score,
    // [111:81] out_room_id, [116:112] position, [121:117] tier_count,
    // [128:122] total_count, [135:129] zero
    output logic [135:0] m_tdata,
    // [2:0] status
    output logic [2:0]   m_tuser,
    output logic         m_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    state_t state_reg, state_next;
    mode_t  mode_reg, mode_next;
    logic [30:0] id_reg, id_next;
    logic [15:0] handle_reg, handle_next;
    logic [31:0] score_reg, score_next;
    logic [SEAT_W-1:0] seat_reg, seat_next;
    logic [30:0] room_reg, room_next;
    logic [TIER_W-1:0] tier_reg, tier_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic [SEAT_W-1:0] k_reg, k_next;
    status_t status_reg, status_next;
    logic [CNT_W-1:0] pos_reg, pos_next;
    logic [CNT_W-1:0] counts_reg [NUM_TIERS];
    logic [CNT_W-1:0] counts_next [NUM_TIERS];
    logic [SEAT_W-1:0] seats_reg [NUM_TIERS];
    logic [SEAT_W-1:0] seats_next [NUM_TIERS];
    logic signed [31:0] lim1_reg, lim1_next, lim2_reg, lim2_next, lim3_reg, lim3_next;
    result_t out_reg, out_next;
    status_t ostat_reg, ostat_next;
    logic olast_reg, olast_next;
    logic m_valid_reg, m_valid_next;

    // RAM port
    logic ram_we, ram_re;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    entry_t ram_wdata, ram_rdata;

    tbmq_ram #(.WIDTH(ENTRY_W), .DEPTH(NUM_TIERS * TIER_DEPTH)) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Shared conditions
    logic s_acc, out_free, idx_in, tier_full, hit, shift_more, ready_any;
    logic [CNT_W-1:0] cur_cnt;
    logic [TOT_W-1:0] total;
    logic [TIER_W-1:0] join_tier, ready_tier;
    logic signed [31:0] in_score;
    mode_t in_mode;

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign s_acc     = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;
    assign in_score  = $signed(s_tdata[78:47]);
    assign in_mode   = mode_t'(s_tuser);
    assign cur_cnt   = counts_reg[tier_reg];
    assign idx_in    = idx_reg < cur_cnt;
    assign tier_full = cur_cnt >= CNT_W'(TIER_DEPTH);
    assign hit       = ram_rdata.id == id_reg;
    assign shift_more = ({1'b0, idx_reg} + (CNT_W+1)'(1)) < {1'b0, n_reg};

    always_comb begin
        total = '0;
        for (int t = 0; t < NUM_TIERS; t++) begin
            total = total + TOT_W'(counts_reg[t]);
        end
    end

    always_comb begin
        priority if (in_score <= lim1_reg) join_tier = 2'd0;
        else if (in_score <= lim2_reg) join_tier = 2'd1;
        else if (in_score <= lim3_reg) join_tier = 2'd2;
        else join_tier = 2'd3;
    end

    // Highest tier holding at least its seat count
    always_comb begin
        ready_any  = 1'b0;
        ready_tier = '0;
        for (int t = 0; t < NUM_TIERS; t++) begin
            if (seats_reg[t] != '0 && counts_reg[t] >= CNT_W'(seats_reg[t])) begin
                ready_any  = 1'b1;
                ready_tier = TIER_W'(t);
            end
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_acc) begin
                    unique case (in_mode)
                        MODE_JOIN, MODE_LEAVE, MODE_POS: state_next = S_SRCH_RD;
                        MODE_BUILD: state_next = ready_any ? S_POP_RD : S_EMIT;
                        MODE_STATS: state_next = S_STATS;
                        MODE_CLEAR: state_next = S_EMIT;
                        default:    state_next = S_IDLE;
                    endcase
                end
            end
            S_SRCH_RD: begin
                priority if (idx_in) state_next = S_SRCH_CMP;
                else if (mode_reg == MODE_JOIN) state_next = S_EMIT;
                else if (tier_reg == TIER_W'(NUM_TIERS - 1)) state_next = S_EMIT;
                else state_next = S_SRCH_RD;
            end
            S_SRCH_CMP: begin
                if (hit) begin
                    state_next = (mode_reg == MODE_LEAVE) ? S_SHIFT_RD : S_EMIT;
                end else begin
                    state_next = S_SRCH_RD;
                end
            end
            S_SHIFT_RD: begin
                priority if (shift_more) state_next = S_SHIFT_WR;
                else if (mode_reg == MODE_LEAVE) state_next = S_EMIT;
                else if (k_reg == seats_reg[tier_reg]) state_next = S_IDLE;
                else state_next = S_POP_RD;
            end
            S_SHIFT_WR: state_next = S_SHIFT_RD;
            S_POP_RD:   state_next = S_POP_EMIT;
            S_POP_EMIT: if (out_free) state_next = S_SHIFT_RD;
            S_EMIT:     if (out_free) state_next = S_IDLE;
            S_STATS:    if (out_free && k_reg == SEAT_W'(NUM_TIERS - 1)) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb begin
        mode_next   = mode_reg;
        id_next     = id_reg;
        handle_next = handle_reg;
        score_next  = score_reg;
        seat_next   = seat_reg;
        room_next   = room_reg;
        tier_next   = tier_reg;
        idx_next    = idx_reg;
        n_next      = n_reg;
        k_next      = k_reg;
        status_next = status_reg;
        pos_next    = pos_reg;
        counts_next = counts_reg;
        seats_next  = seats_reg;
        lim1_next   = lim1_reg;
        lim2_next   = lim2_reg;
        lim3_next   = lim3_reg;
        out_next    = out_reg;
        ostat_next  = ostat_reg;
        olast_next  = olast_reg;
        m_valid_next = m_valid_reg && !m_tready;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_waddr = {tier_reg, idx_reg[IDX_W-1:0]};
        ram_raddr = {tier_reg, idx_reg[IDX_W-1:0]};
        ram_wdata = ram_rdata;

        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_TIER_ONE:   lim1_next = cfg_data;
                CFG_TIER_TWO:   lim2_next = cfg_data;
                CFG_TIER_THREE: lim3_next = cfg_data;
                default: ;
            endcase
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_acc) begin
                    mode_next   = in_mode;
                    id_next     = s_tdata[30:0];
                    handle_next = s_tdata[46:31];
                    score_next  = s_tdata[78:47];
                    seat_next   = s_tdata[81:79];
                    room_next   = s_tdata[112:82];
                    idx_next    = '0;
                    k_next      = '0;
                    pos_next    = '0;
                    status_next = ST_OK;
                    tier_next   = '0;
                    if (in_mode == MODE_JOIN) tier_next = join_tier;
                    if (in_mode == MODE_BUILD) begin
                        tier_next = ready_any ? ready_tier : '0;
                        status_next = ready_any ? ST_OK : ST_NO_MATCH;
                    end
                    if (in_mode == MODE_CLEAR) begin
                        for (int t = 0; t < NUM_TIERS; t++) counts_next[t] = '0;
                    end
                end
            end
            S_SRCH_RD: begin
                priority if (idx_in) begin
                    ram_re = 1'b1;
                end else if (mode_reg == MODE_JOIN) begin
                    if (tier_full) begin
                        status_next = ST_FULL;
                    end else begin
                        ram_we    = 1'b1;
                        ram_waddr = {tier_reg, cur_cnt[IDX_W-1:0]};
                        ram_wdata = '{id: id_reg, handle: handle_reg, score: score_reg};
                        counts_next[tier_reg] = cur_cnt + CNT_W'(1);
                        pos_next = cur_cnt + CNT_W'(1);
                        if (seat_reg >= SEATS_MIN && seat_reg <= SEAT_W'(MAX_SEATS)) begin
                            seats_next[tier_reg] = seat_reg;
                        end
                    end
                end else if (tier_reg == TIER_W'(NUM_TIERS - 1)) begin
                    status_next = ST_NOT_FOUND;
                    tier_next   = '0;
                end else begin
                    tier_next = tier_reg + TIER_W'(1);
                    idx_next  = '0;
                end
            end
            S_SRCH_CMP: begin
                if (hit) begin
                    pos_next = idx_reg + CNT_W'(1);
                    status_next = (mode_reg == MODE_JOIN) ? ST_ALREADY : ST_OK;
                    if (mode_reg == MODE_LEAVE) begin
                        n_next = cur_cnt;
                        counts_next[tier_reg] = cur_cnt - CNT_W'(1);
                    end
                end else begin
                    idx_next = idx_reg + CNT_W'(1);
                end
            end
            S_SHIFT_RD: begin
                if (shift_more) begin
                    ram_re    = 1'b1;
                    ram_raddr = {tier_reg, IDX_W'(idx_reg + CNT_W'(1))};
                end
            end
            S_SHIFT_WR: begin
                ram_we   = 1'b1;
                idx_next = idx_reg + CNT_W'(1);
            end
            S_POP_RD: begin
                ram_re    = 1'b1;
                ram_raddr = {tier_reg, {IDX_W{1'b0}}};
                idx_next  = '0;
            end
            S_POP_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    ostat_next   = ST_OK;
                    olast_next   = (k_reg + SEAT_W'(1)) == seats_reg[tier_reg];
                    out_next = '{total_count: 7'(total - TOT_W'(1)),
                                 tier_count: 5'(cur_cnt - CNT_W'(1)),
                                 position: 5'(k_reg + SEAT_W'(1)),
                                 room_id: room_reg,
                                 score: ram_rdata.score,
                                 handle: ram_rdata.handle,
                                 player_id: ram_rdata.id,
                                 tier: tier_reg};
                    counts_next[tier_reg] = cur_cnt - CNT_W'(1);
                    n_next   = cur_cnt;
                    k_next   = k_reg + SEAT_W'(1);
                    idx_next = '0;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    ostat_next   = status_reg;
                    olast_next   = 1'b1;
                    out_next = '{total_count: 7'(total), tier_count: 5'(cur_cnt),
                                 position: 5'(pos_reg), room_id: '0, score: '0,
                                 handle: '0, player_id: '0, tier: tier_reg};
                end
            end
            S_STATS: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    ostat_next   = ST_OK;
                    olast_next   = k_reg == SEAT_W'(NUM_TIERS - 1);
                    out_next = '{total_count: 7'(total),
                                 tier_count: 5'(counts_reg[k_reg[TIER_W-1:0]]),
                                 position: '0, room_id: '0, score: '0,
                                 handle: '0, player_id: '0, tier: k_reg[TIER_W-1:0]};
                    k_next = k_reg + SEAT_W'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            lim1_reg    <= LIMIT_ONE_RST;
            lim2_reg    <= LIMIT_TWO_RST;
            lim3_reg    <= LIMIT_THREE_RST;
            for (int t = 0; t < NUM_TIERS; t++) begin
                counts_reg[t] <= '0;
                seats_reg[t]  <= SEATS_RST;
            end
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            lim1_reg    <= lim1_next;
            lim2_reg    <= lim2_next;
            lim3_reg    <= lim3_next;
            counts_reg  <= counts_next;
            seats_reg   <= seats_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg   <= mode_next;
        id_reg     <= id_next;
        handle_reg <= handle_next;
        score_reg  <= score_next;
        seat_reg   <= seat_next;
        room_reg   <= room_next;
        tier_reg   <= tier_next;
        idx_reg    <= idx_next;
        n_reg      <= n_next;
        k_reg      <= k_next;
        status_reg <= status_next;
        pos_reg    <= pos_next;
        out_reg    <= out_next;
        ostat_reg  <= ostat_next;
        olast_reg  <= olast_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, out_reg};
    assign m_tuser  = ostat_reg;
    assign m_tlast  = olast_reg;

    // Checks
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        counts_reg[0] <= CNT_W'(TIER_DEPTH) && counts_reg[1] <= CNT_W'(TIER_DEPTH) &&
        counts_reg[2] <= CNT_W'(TIER_DEPTH) && counts_reg[3] <= CNT_W'(TIER_DEPTH))
        else $error("tier count above depth");

    a_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && in_mode == MODE_CLEAR |=> total == '0)
        else $error("clear left entries");

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_POP_RD |-> cur_cnt != '0)
        else $error("pop from empty tier");

    a_wr_state: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == S_SRCH_RD || state_reg == S_SHIFT_WR))
        else $error("unexpected RAM write");

endmodule
